@@ rtl/fat12_pkg.sv @@
`default_nettype none

package fat12_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_START   = 2'd1;
  localparam logic [1:0] KIND_ADVANCE = 2'd2;

  // Field widths fixed by the interface
  localparam int ClusterW = 12;
  localparam int LengthW  = 31;
  localparam int SectorW  = 13;
  localparam int CountW   = 10;
  localparam int OffsetW  = 14;

  // Entries at or above this value end a chain
  localparam logic [ClusterW-1:0] CHAIN_END_MIN = 12'hFF8;

  // Reset value of the data start sector register
  localparam logic [ClusterW-1:0] DATA_START_RESET = 12'd33;

  // Unpacked table entry
  typedef struct packed {
    logic [ClusterW-1:0] next_cluster;
    logic                chain_end;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/fat12_ram.sv @@
`default_nettype none

// Simple dual-port RAM, one write port, one registered read port
module fat12_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/fat12_unpack.sv @@
`default_nettype none

// Byte offsets of a cluster's 12-bit entry, and the entry unpacked from its two bytes
module fat12_unpack import fat12_pkg::*; #(
  parameter int TABLE_BYTES = 8192,
  localparam int AddrW = $clog2(TABLE_BYTES)
) (
  input  logic [ClusterW-1:0] cluster,
  input  logic [7:0]          byte_lo,
  input  logic [7:0]          byte_hi,
  output logic [AddrW-1:0]    addr_lo,
  output logic [AddrW-1:0]    addr_hi,
  output entry_t              entry
);

  localparam logic [OffsetW-1:0] TableLimit = OffsetW'(TABLE_BYTES);

  logic [OffsetW-1:0]  off_lo;
  logic [OffsetW-1:0]  off_hi;
  logic [7:0]          b0;
  logic [7:0]          b1;
  logic [ClusterW-1:0] value;

  // 3*c/2 rounded down is c + c/2
  assign off_lo  = OffsetW'({2'b00, cluster}) + OffsetW'({3'b000, cluster[ClusterW-1:1]});
  assign off_hi  = off_lo + OffsetW'(1);
  assign addr_lo = off_lo[AddrW-1:0];
  assign addr_hi = off_hi[AddrW-1:0];

  // bytes past the end of the table read as zero
  assign b0 = (off_lo < TableLimit) ? byte_lo : 8'd0;
  assign b1 = (off_hi < TableLimit) ? byte_hi : 8'd0;

  // even cluster: low byte plus low nibble above; odd: high nibble plus byte above
  assign value = cluster[0] ? {b1, b0[7:4]} : {b1[3:0], b0};

  assign entry.next_cluster = value;
  assign entry.chain_end    = (value >= CHAIN_END_MIN);

endmodule

`default_nettype wire

@@ rtl/fat12_cluster_chain_walker.sv @@
`default_nettype none

// Channel   Direction  Handshake           Word
// input     in         in_valid/in_stall   kind, table_address, table_byte,
//                                          start_cluster, file_length
// output    out        out_valid/out_stall sector_index, byte_count, last_block,
//                                          no_chain
// config    in         cfg_wr_en           cfg_wr_data (data start sector)
//
// Load and start words are taken in IDLE. An advance on an active chain goes
// through FETCH_HI and EMIT, as the two entry bytes come one after the other
// from the single read port of the table RAM; without a chain it goes to EMIT.
// Synchronous reset clears the chain and sets the data start sector to 33;
// table contents are not cleared. A result waits in the output register
// while load and start words keep flowing; a further advance holds in EMIT
// until the output register frees up.
module fat12_cluster_chain_walker import fat12_pkg::*; #(
  parameter int TABLE_BYTES  = 8192,
  parameter int SECTOR_BYTES = 512
) (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          kind,
  input  logic [12:0]         table_address,
  input  logic [7:0]          table_byte,
  input  logic [ClusterW-1:0] start_cluster,
  input  logic [LengthW-1:0]  file_length,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SectorW-1:0]  sector_index,
  output logic [CountW-1:0]   byte_count,
  output logic                last_block,
  output logic                no_chain,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [ClusterW-1:0] cfg_wr_data
);

  localparam int AddrW = $clog2(TABLE_BYTES);
  localparam logic [OffsetW-1:0] TableLimit = OffsetW'(TABLE_BYTES);
  localparam logic [LengthW-1:0] SectorLen  = LengthW'(SECTOR_BYTES);

  typedef enum logic [1:0] {
    IDLE,
    FETCH_HI,
    EMIT
  } state_t;

  state_t              state;
  logic [ClusterW-1:0] current_cluster;
  logic [LengthW-1:0]  remaining;
  logic                chain_active;
  logic [ClusterW-1:0] data_start;
  logic                no_chain_pend;
  logic [7:0]          byte_lo;

  logic                accept;
  logic                load_en;
  logic [AddrW-1:0]    addr_lo;
  logic [AddrW-1:0]    addr_hi;
  logic [AddrW-1:0]    rd_addr;
  logic [7:0]          rd_data;
  entry_t              entry;

  logic                rem_over;
  logic [LengthW-1:0]  count_full;
  logic [LengthW-1:0]  remaining_next;
  logic                last_next;
  logic [SectorW-1:0]  sector_next;
  logic                out_free;

  // Input handshake
  assign in_stall = (state != IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_en  = accept && (kind == KIND_LOAD)
                    && (OffsetW'({1'b0, table_address}) < TableLimit);

  // Table store: low byte read at accept, high byte in FETCH_HI and held in EMIT
  assign rd_addr = (state == IDLE) ? addr_lo : addr_hi;

  fat12_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_BYTES)
  ) u_table (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (table_address[AddrW-1:0]),
    .wr_data (table_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fat12_unpack #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_unpack (
    .cluster (current_cluster),
    .byte_lo (byte_lo),
    .byte_hi (rd_data),
    .addr_lo (addr_lo),
    .addr_hi (addr_hi),
    .entry   (entry)
  );

  // Block size, remaining length and sector for the current cluster
  assign rem_over       = (remaining > SectorLen);
  assign count_full     = rem_over ? SectorLen : remaining;
  assign remaining_next = rem_over ? (remaining - SectorLen) : '0;
  assign last_next      = entry.chain_end || (remaining_next == '0);
  assign sector_next    = SectorW'({1'b0, data_start}) + SectorW'({1'b0, current_cluster})
                          - SectorW'(2);
  assign out_free       = !out_valid || !out_stall;

  // Sequencer, chain state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      out_valid       <= 1'b0;
      current_cluster <= '0;
      remaining       <= '0;
      chain_active    <= 1'b0;
      data_start      <= DATA_START_RESET;
      no_chain_pend   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        data_start <= cfg_wr_data;
      end
      // result taken; in EMIT the next one is loaded in the same cycle
      if (out_valid && !out_stall && (state != EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (accept) begin
            unique case (kind)
              KIND_START: begin
                current_cluster <= start_cluster;
                remaining       <= file_length;
                chain_active    <= 1'b1;
              end
              KIND_ADVANCE: begin
                no_chain_pend <= !chain_active;
                state         <= chain_active ? FETCH_HI : EMIT;
              end
              default: begin
                // loads go straight to the RAM; unused kind is dropped
              end
            endcase
          end
        end
        FETCH_HI: begin
          byte_lo <= rd_data;
          state   <= EMIT;
        end
        EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= IDLE;
            if (no_chain_pend) begin
              sector_index <= '0;
              byte_count   <= '0;
              last_block   <= 1'b0;
              no_chain     <= 1'b1;
            end else begin
              sector_index <= sector_next;
              byte_count   <= count_full[CountW-1:0];
              last_block   <= last_next;
              no_chain     <= 1'b0;
              remaining    <= remaining_next;
              if (last_next) begin
                chain_active <= 1'b0;
              end else begin
                current_cluster <= entry.next_cluster;
              end
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // A new result only comes out of EMIT
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == EMIT))
    else $error("result appeared outside EMIT");

  // A no-chain result carries zero fields
  a_no_chain_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_chain) |-> (sector_index == '0 && byte_count == '0 && !last_block))
    else $error("no-chain result with nonzero fields");

  // A block that is not last is a full sector and leaves the chain active
  a_mid_block: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !no_chain && !last_block)
      |-> (byte_count == SectorLen[CountW-1:0] && chain_active))
    else $error("middle block not full or chain dropped");

  // Table reads are only in flight while an advance walks an active chain
  a_fetch_active: assert property (@(posedge clk) disable iff (rst)
    (state == FETCH_HI) |-> (chain_active && !no_chain_pend))
    else $error("entry fetch without active chain");

endmodule

`default_nettype wire
